### design/kmpq_pkg.sv
package kmpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int PRIO_BITS = 16;
    localparam int SEQ_BITS  = 32;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_RAISE  = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0]  id;
        logic [PRIO_BITS-1:0] prio;
        logic [SEQ_BITS-1:0]  seq;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

### design/keyed_max_priority_queue.sv
// Keyed max priority queue over a table of CAPACITY slots.
// Input channel (i_valid / o_ready) carries one beat per operation: insert a key
// with a starting priority, raise the priority of every slot with a key, or
// remove every slot with a key; action 3 only queries. Output channel
// (o_valid / i_ready) returns exactly one beat per input beat: the top key and
// priority (highest priority, earlier arrival on a tie), an empty flag and a
// status (ok, insert dropped on a full table, key not found).
// Each beat is handled by one pass of a single compare/update unit over the
// slot memory, one slot per cycle, with the memory read registered. The
// result is held in the output registers at the end of the pass, and the
// next input beat can be taken only after the result leaves. The slot
// count, not the arithmetic, sets the length of a pass.
// o_ready is high only while the block is idle. A stalled receiver holds the
// result in the output registers and the block takes no new beat until then.
// Reset clears all slot valid bits, the slot count and the arrival counter;
// there is no clearing pass, and slot contents are written before first use.
module keyed_max_priority_queue
    import kmpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_action,
    input  logic [KEY_BITS-1:0]  i_entry_key,
    input  logic [PRIO_BITS-1:0] i_amount,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [KEY_BITS-1:0]  o_top_key,
    output logic [PRIO_BITS-1:0] o_top_priority,
    output logic                 o_queue_empty,
    output logic [1:0]           o_status
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [IDX_BITS-1:0]   r_pidx;
    logic [1:0]            r_act;
    logic [KEY_BITS-1:0]   r_key;
    logic [PRIO_BITS-1:0]  r_amt;
    logic                  r_full;
    logic                  r_ins_done, n_ins_done;
    logic                  r_hit, n_hit;
    logic                  r_found, n_found;
    logic [PRIO_BITS-1:0]  r_best_p, n_best_p;
    logic [SEQ_BITS-1:0]   r_best_s, n_best_s;
    logic [KEY_BITS-1:0]   r_best_k, n_best_k;
    logic [CAPACITY-1:0]   r_valid;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [SEQ_BITS-1:0]   r_arrival, n_arrival;

    logic [KEY_BITS-1:0]   r_top_key;
    logic [PRIO_BITS-1:0]  r_top_prio;
    logic                  r_empty;
    logic [1:0]            r_status, n_status;

    logic [IDX_BITS-1:0]   rd_addr;
    logic                  proc;
    logic                  cur_v;
    logic                  match;
    logic                  ins;
    logic                  eff_v;
    t_entry                eff;
    logic                  wr_en;
    logic [PRIO_BITS:0]    sum;
    logic                  better;

    assign rd_addr = r_cnt[IDX_BITS-1:0];
    assign proc    = (r_state == S_SCAN) && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_pidx    <= rd_addr;
        if (wr_en) begin
            r_mem[r_pidx] <= eff;
        end
    end

    always_comb begin
        cur_v      = r_valid[r_pidx];
        match      = cur_v && (r_rd_data.id == r_key);
        ins        = (r_act == ACT_INSERT) && !r_full && !r_ins_done && !cur_v;
        sum        = {1'b0, r_rd_data.prio} + {1'b0, r_amt};
        eff        = r_rd_data;
        eff_v      = cur_v;
        wr_en      = 1'b0;
        n_ins_done = r_ins_done;
        n_hit      = r_hit;
        n_count    = r_count;
        n_arrival  = r_arrival;
        if (proc) begin
            case (r_act)
                ACT_INSERT: begin
                    if (ins) begin
                        n_arrival  = r_arrival + 1'b1;
                        eff.id     = r_key;
                        eff.prio   = r_amt;
                        eff.seq    = n_arrival;
                        eff_v      = 1'b1;
                        wr_en      = 1'b1;
                        n_ins_done = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                end
                ACT_RAISE: begin
                    if (match) begin
                        eff.prio = sum[PRIO_BITS] ? '1 : sum[PRIO_BITS-1:0];
                        wr_en    = 1'b1;
                        n_hit    = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (match) begin
                        eff_v   = 1'b0;
                        n_hit   = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        better = eff_v && (!r_found || (eff.prio > r_best_p) ||
                 ((eff.prio == r_best_p) && (eff.seq < r_best_s)));
        n_found  = r_found;
        n_best_p = r_best_p;
        n_best_s = r_best_s;
        n_best_k = r_best_k;
        if (proc && better) begin
            n_found  = 1'b1;
            n_best_p = eff.prio;
            n_best_s = eff.seq;
            n_best_k = eff.id;
        end
        case (r_act)
            ACT_INSERT: n_status = r_full ? ST_FULL : ST_OK;
            ACT_RAISE:  n_status = n_hit ? ST_OK : ST_MISS;
            ACT_REMOVE: n_status = n_hit ? ST_OK : ST_MISS;
            default:    n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_valid   <= '0;
            r_count   <= '0;
            r_arrival <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_act      <= i_action;
                        r_key      <= i_entry_key;
                        r_amt      <= i_amount;
                        r_full     <= (r_count == CNT_BITS'(CAPACITY));
                        r_ins_done <= 1'b0;
                        r_hit      <= 1'b0;
                        r_found    <= 1'b0;
                        r_cnt      <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_ins_done <= n_ins_done;
                    r_hit      <= n_hit;
                    r_found    <= n_found;
                    r_best_p   <= n_best_p;
                    r_best_s   <= n_best_s;
                    r_best_k   <= n_best_k;
                    r_count    <= n_count;
                    r_arrival  <= n_arrival;
                    if (proc) begin
                        r_valid[r_pidx] <= eff_v;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(CAPACITY)) begin
                        r_top_key  <= n_found ? n_best_k : '0;
                        r_top_prio <= n_found ? n_best_p : '0;
                        r_empty    <= !n_found;
                        r_status   <= n_status;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_top_key      = r_top_key;
    assign o_top_priority = r_top_prio;
    assign o_queue_empty  = r_empty;
    assign o_status       = r_status;

endmodule

### design/kmpq_checker.sv
module kmpq_port_checks
    import kmpq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [1:0]           i_action,
    input logic [KEY_BITS-1:0]  i_entry_key,
    input logic [PRIO_BITS-1:0] i_amount,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [KEY_BITS-1:0]  o_top_key,
    input logic [PRIO_BITS-1:0] o_top_priority,
    input logic                 o_queue_empty,
    input logic [1:0]           o_status
);

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_queue_empty |-> (o_top_key == '0) && (o_top_priority == '0))
        else $error("empty result carries nonzero top fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_FULL) ||
                    (o_status == ST_MISS))
        else $error("undefined status code");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !o_valid)
        else $error("input beat not followed by busy period");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_top_key) &&
                                $stable(o_top_priority) && $stable(o_status))
        else $error("stalled result beat changed");

endmodule

bind keyed_max_priority_queue kmpq_port_checks u_kmpq_checker (.*);
